[design/khs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// khs_pkg: shared types and constants for the key hash slot block
// CRC-16/XMODEM byte update, brace codes, tag phase encoding and widths.
// ----------------------------------------------------------------------------
package khs_pkg;

	localparam int unsigned  CRC_W         = 16;
	localparam int unsigned  SLOT_W        = 14;
	localparam int unsigned  SLOT_BITS_DEF = 14;
	localparam logic [15:0]  CRC_POLY      = 16'h1021;
	localparam logic [7:0]   OPEN_BRACE    = 8'h7B;
	localparam logic [7:0]   CLOSE_BRACE   = 8'h7D;

	typedef enum logic [1:0] {
		TAG_SEARCH = 2'd0,
		TAG_INSIDE = 2'd1,
		TAG_CLOSED = 2'd2
	} tag_phase_t;

	// One byte of CRC-16/XMODEM, MSB first, no reflection.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[design/key_hash_slot_with_hashtag.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_hash_slot_with_hashtag: cluster hash slot of each key, with hash tags
// Runs CRC-16/XMODEM over each key and over its {tag}, emits the slot at the
// end of every key and flags requests whose keys span more than one slot.
// ----------------------------------------------------------------------------
//  channel | signals                 | item
//  --------+-------------------------+--------------------------------------
//  s_      | tvalid tready tdata     | key_byte in tdata[7:0]
//          | tlast tuser             | tlast = key_end, tuser = request_end
//  m_      | tvalid tready tdata     | slot in tdata[13:0]
//          | tlast tuser             | tlast = last_key, tuser = cross_slot
//
// One byte is taken every cycle unless a stalled result holds a key-ending byte.
// The byte that ends a key passes the input register, then the result register,
// with the byte-wide CRC update between those registers.
// arst_n clears all key and request state. A stalled result holds the input
// register only when that byte ends a key; other bytes keep flowing.
// ----------------------------------------------------------------------------
module key_hash_slot_with_hashtag
	import khs_pkg::*;
#(
	parameter int unsigned SLOT_BITS = SLOT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] key_byte
	input  wire logic        s_tlast,
	input  wire logic        s_tuser,   // [0] request_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [13:0] slot, [15:14] zero
	output logic             m_tlast,
	output logic             m_tuser    // [0] cross_slot
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       key_end_s1;
	logic       req_end_s1;

	// key and request state
	logic [CRC_W-1:0]     whole_crc_q;
	logic [CRC_W-1:0]     tag_crc_q;
	tag_phase_t           tag_phase_q;
	logic                 tag_nonempty_q;
	logic [SLOT_BITS-1:0] first_slot_q;
	logic                 have_first_q;
	logic                 mismatch_q;

	// result register
	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              out_cross_q;
	logic              out_last_q;

	logic                 fire;
	logic [CRC_W-1:0]     whole_crc_n;
	logic [CRC_W-1:0]     tag_crc_upd;
	logic [CRC_W-1:0]     tag_crc_n;
	tag_phase_t           tag_phase_n;
	logic                 tag_nonempty_n;
	logic                 tag_done;
	logic [CRC_W-1:0]     slot_src;
	logic [SLOT_BITS-1:0] slot_full;
	logic [15:0]          slot_ext;
	logic                 mismatch_n;

	// a byte that ends a key needs a free result register
	assign fire     = valid_s1 && (!key_end_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1    <= s_tdata;
			key_end_s1 <= s_tlast;
			req_end_s1 <= s_tuser;
		end
	end

	assign whole_crc_n = crc16_byte(whole_crc_q, byte_s1);
	assign tag_crc_upd = crc16_byte(tag_crc_q, byte_s1);

	// tag phase: next state
	always_comb begin
		tag_phase_n = tag_phase_q;
		unique case (tag_phase_q)
			TAG_SEARCH: begin
				if (byte_s1 == OPEN_BRACE) tag_phase_n = TAG_INSIDE;
			end
			TAG_INSIDE: begin
				if (byte_s1 == CLOSE_BRACE) tag_phase_n = TAG_CLOSED;
			end
			default: tag_phase_n = tag_phase_q;
		endcase
	end

	// tag CRC and fill flag
	always_comb begin
		tag_crc_n      = tag_crc_q;
		tag_nonempty_n = tag_nonempty_q;
		unique case (tag_phase_q)
			TAG_SEARCH: begin
				if (byte_s1 == OPEN_BRACE) begin
					tag_crc_n      = '0;
					tag_nonempty_n = 1'b0;
				end
			end
			TAG_INSIDE: begin
				if (byte_s1 != CLOSE_BRACE) begin
					tag_crc_n      = tag_crc_upd;
					tag_nonempty_n = 1'b1;
				end
			end
			default: begin
				tag_crc_n      = tag_crc_q;
				tag_nonempty_n = tag_nonempty_q;
			end
		endcase
	end

	// the unused phase code counts as closed
	assign tag_done   = (tag_phase_n != TAG_SEARCH) && (tag_phase_n != TAG_INSIDE);
	assign slot_src   = (tag_done && tag_nonempty_n) ? tag_crc_n : whole_crc_n;
	assign slot_full  = slot_src[SLOT_BITS-1:0];
	assign slot_ext   = 16'(slot_full);
	assign mismatch_n = mismatch_q || (have_first_q && (slot_full != first_slot_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_crc_q    <= '0;
			tag_crc_q      <= '0;
			tag_phase_q    <= TAG_SEARCH;
			tag_nonempty_q <= 1'b0;
			first_slot_q   <= '0;
			have_first_q   <= 1'b0;
			mismatch_q     <= 1'b0;
		end else if (fire) begin
			if (key_end_s1) begin
				// drop key state for the next key
				whole_crc_q    <= '0;
				tag_crc_q      <= '0;
				tag_phase_q    <= TAG_SEARCH;
				tag_nonempty_q <= 1'b0;
				if (req_end_s1) begin
					first_slot_q <= '0;
					have_first_q <= 1'b0;
					mismatch_q   <= 1'b0;
				end else begin
					if (!have_first_q) first_slot_q <= slot_full;
					have_first_q <= 1'b1;
					mismatch_q   <= mismatch_n;
				end
			end else begin
				whole_crc_q    <= whole_crc_n;
				tag_crc_q      <= tag_crc_n;
				tag_phase_q    <= tag_phase_n;
				tag_nonempty_q <= tag_nonempty_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && key_end_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && key_end_s1) begin
			out_slot_q  <= slot_ext[SLOT_W-1:0];
			out_cross_q <= mismatch_n;
			out_last_q  <= req_end_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = 16'(out_slot_q);
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_cross_q;

`ifndef SYNTH
	a_result_follows_key_end: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && key_end_s1) |=> m_tvalid)
		else $error("no result after a key end");

	a_key_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && key_end_s1) |=> (whole_crc_q == '0 && tag_phase_q == TAG_SEARCH))
		else $error("key state not cleared at key end");

	a_mismatch_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		!have_first_q |-> !mismatch_q)
		else $error("cross slot flag set without a first slot");

	a_request_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && key_end_s1 && req_end_s1) |=> (!have_first_q && !mismatch_q))
		else $error("request state not cleared at request end");
`endif

endmodule
`default_nettype wire
